// ----- hdl/lsvp_pkg.sv -----
// ----------------------------------------------------------------------------
// lsvp_pkg
// Shared widths, codes and request/result types of the Loop vertex-point unit.
// ----------------------------------------------------------------------------
package lsvp_pkg;

  localparam int POS_W       = 32;
  localparam int MAX_VALENCE = 16;
  localparam int NBR_TRI     = 3;

  localparam int CNT_W = $clog2(MAX_VALENCE + 1);
  localparam int SUM_W = POS_W + CNT_W;
  localparam int NUM_W = POS_W + 3 + CNT_W;
  localparam int U_W   = NUM_W - 3;

  localparam int DIV_DIGIT  = 4;
  localparam int DIV_STAGES = (U_W + DIV_DIGIT - 1) / DIV_DIGIT;
  localparam int DIV_W      = DIV_STAGES * DIV_DIGIT;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_NBR   = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic signed [NUM_W-1:0] num_t;
  typedef logic signed [U_W-1:0]   u_t;
  typedef logic [U_W-1:0]          mag_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [1:0]              status_t;

  typedef struct packed {
    logic start_vertex;
    logic boundary;
    logic last_item;
    pos_t pos_x;
    pos_t pos_y;
    pos_t pos_z;
  } req_t;

  typedef struct packed {
    pos_t    new_x;
    pos_t    new_y;
    pos_t    new_z;
    status_t status;
  } result_t;

  typedef struct packed {
    logic       bnd;
    logic       ovf;
    cnt_t       cnt;
    pos_t [2:0] center;
    sum_t [2:0] sum;
    pos_t [2:0] first;
    pos_t [2:0] lastn;
  } fin_t;

  typedef struct packed {
    mag_t [2:0] mag;
    logic [2:0] neg;
    cnt_t       den;
    status_t    status;
  } prep_t;

  typedef struct packed {
    logic [2:0] neg;
    status_t    status;
  } side_t;

endpackage

// ----- hdl/lsvp_accum.sv -----
// ----------------------------------------------------------------------------
// lsvp_accum
// Collects one vertex run: center, neighbor sums, first and last neighbor.
// ----------------------------------------------------------------------------
module lsvp_accum import lsvp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic take,
  input  req_t req,
  output fin_t fin,
  output logic fin_valid
);

  pos_t center [3];
  pos_t first  [3];
  pos_t lastn  [3];
  sum_t sum    [3];
  pos_t center_next [3];
  pos_t first_next  [3];
  pos_t lastn_next  [3];
  sum_t sum_next    [3];
  cnt_t cnt, cnt_next;
  logic bnd, bnd_next;
  logic ovf, ovf_next;
  logic open, open_next;
  logic fire;
  pos_t p [3];

  assign p[0] = req.pos_x;
  assign p[1] = req.pos_y;
  assign p[2] = req.pos_z;

  always_comb begin
    center_next = center;
    first_next  = first;
    lastn_next  = lastn;
    sum_next    = sum;
    cnt_next    = cnt;
    bnd_next    = bnd;
    ovf_next    = ovf;
    open_next   = open;
    fire        = 1'b0;
    if (take) begin
      if (req.start_vertex) begin
        for (int k = 0; k < 3; k++) begin
          center_next[k] = p[k];
          sum_next[k]    = '0;
          first_next[k]  = '0;
          lastn_next[k]  = '0;
        end
        bnd_next  = req.boundary;
        cnt_next  = '0;
        ovf_next  = 1'b0;
        open_next = 1'b1;
      end else if (open) begin
        if (cnt < CNT_W'(MAX_VALENCE)) begin
          for (int k = 0; k < 3; k++) begin
            if (cnt == '0) begin
              first_next[k] = p[k];
            end
            lastn_next[k] = p[k];
            sum_next[k]   = sum[k] + sum_t'(p[k]);
          end
          cnt_next = cnt + 1'b1;
        end else begin
          ovf_next = 1'b1;
        end
      end
      if (req.last_item && (req.start_vertex || open)) begin
        fire      = 1'b1;
        open_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      bnd       <= 1'b0;
      ovf       <= 1'b0;
      open      <= 1'b0;
      fin_valid <= 1'b0;
    end else begin
      cnt       <= cnt_next;
      bnd       <= bnd_next;
      ovf       <= ovf_next;
      open      <= open_next;
      fin_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    center <= center_next;
    first  <= first_next;
    lastn  <= lastn_next;
    sum    <= sum_next;
    if (fire) begin
      fin.bnd <= bnd_next;
      fin.ovf <= ovf_next;
      fin.cnt <= cnt_next;
      for (int k = 0; k < 3; k++) begin
        fin.center[k] <= center_next[k];
        fin.sum[k]    <= sum_next[k];
        fin.first[k]  <= first_next[k];
        fin.lastn[k]  <= lastn_next[k];
      end
    end
  end

endmodule

// ----- hdl/lsvp_prep.sv -----
// ----------------------------------------------------------------------------
// lsvp_prep
// Forms the weighted numerator, the rounding offset and the divisor,
// and hands a sign/magnitude dividend to the divider.
// ----------------------------------------------------------------------------
module lsvp_prep import lsvp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  fin_t  fin,
  input  logic  fin_valid,
  output prep_t prep,
  output logic  prep_valid
);

  num_t             a_next [3];
  num_t             b_next [3];
  num_t             a1     [3];
  num_t             b1     [3];
  logic [CNT_W+1:0] k_next, k1;
  logic [2:0]       sh_next, sh1;
  cnt_t             den_next, den1, den2;
  status_t          st_next, st1, st2;
  logic             v1, v2;
  u_t               u2 [3];
  logic [CNT_W+2:0] five_n;

  assign five_n = (CNT_W+3)'({fin.cnt, 2'b00}) + (CNT_W+3)'(fin.cnt);

  always_comb begin
    logic signed [POS_W+CNT_W+3:0] prod;
    num_t cx;
    num_t sx;
    k_next   = '0;
    sh_next  = '0;
    den_next = CNT_W'(1);
    st_next  = fin.ovf ? ST_OVERFLOW : ST_OK;
    if (fin.cnt == '0) begin
      st_next = ST_NO_NBR;
    end else if (fin.bnd) begin
      k_next  = (CNT_W+2)'(4);
      sh_next = 3'd3;
    end else if (fin.cnt == CNT_W'(NBR_TRI)) begin
      k_next  = (CNT_W+2)'(8);
      sh_next = 3'd4;
    end else begin
      k_next   = {fin.cnt, 2'b00};
      sh_next  = 3'd3;
      den_next = fin.cnt;
    end
    for (int k = 0; k < 3; k++) begin
      cx   = num_t'($signed(fin.center[k]));
      sx   = num_t'($signed(fin.sum[k]));
      prod = $signed(fin.center[k]) * $signed({1'b0, five_n});
      if (fin.cnt == '0) begin
        a_next[k] = cx;
        b_next[k] = '0;
      end else if (fin.bnd) begin
        a_next[k] = (cx <<< 2) + (cx <<< 1);
        b_next[k] = num_t'($signed(fin.first[k])) + num_t'($signed(fin.lastn[k]));
      end else if (fin.cnt == CNT_W'(NBR_TRI)) begin
        a_next[k] = (cx <<< 3) - cx;
        b_next[k] = (sx <<< 1) + sx;
      end else begin
        a_next[k] = num_t'(prod);
        b_next[k] = (sx <<< 1) + sx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1         <= 1'b0;
      v2         <= 1'b0;
      prep_valid <= 1'b0;
    end else begin
      v1         <= fin_valid;
      v2         <= v1;
      prep_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    num_t acc;
    a1   <= a_next;
    b1   <= b_next;
    k1   <= k_next;
    sh1  <= sh_next;
    den1 <= den_next;
    st1  <= st_next;
    for (int k = 0; k < 3; k++) begin
      acc   = a1[k] + b1[k] + num_t'(k1);
      u2[k] <= u_t'(acc >>> sh1);
    end
    den2 <= den1;
    st2  <= st1;
    for (int k = 0; k < 3; k++) begin
      prep.neg[k] <= u2[k][U_W-1];
      prep.mag[k] <= u2[k][U_W-1] ? (~mag_t'(u2[k]) + mag_t'(den2)) : mag_t'(u2[k]);
    end
    prep.den    <= den2;
    prep.status <= st2;
  end

endmodule

// ----- hdl/lsvp_div.sv -----
// ----------------------------------------------------------------------------
// lsvp_div
// Pipelined restoring divider, unsigned dividend by small valence divisor,
// DIV_DIGIT quotient bits per stage.
// ----------------------------------------------------------------------------
module lsvp_div import lsvp_pkg::*; (
  input  logic clk,
  input  mag_t num,
  input  cnt_t den,
  output mag_t quo
);

  logic [DIV_W-1:0] w_q [DIV_STAGES];
  cnt_t             r_q [DIV_STAGES];
  cnt_t             d_q [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [DIV_W-1:0] w_in, w_out;
    cnt_t             r_in, r_out, d_in;

    if (s == 0) begin : g_first
      assign w_in = DIV_W'(num);
      assign r_in = '0;
      assign d_in = den;
    end else begin : g_next
      assign w_in = w_q[s-1];
      assign r_in = r_q[s-1];
      assign d_in = d_q[s-1];
    end

    always_comb begin
      logic [CNT_W:0] rt;
      w_out = w_in;
      r_out = r_in;
      for (int i = 0; i < DIV_DIGIT; i++) begin
        rt    = {r_out, w_out[DIV_W-1]};
        w_out = {w_out[DIV_W-2:0], 1'b0};
        if (rt >= {1'b0, d_in}) begin
          rt       = rt - {1'b0, d_in};
          w_out[0] = 1'b1;
        end
        r_out = rt[CNT_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      w_q[s] <= w_out;
      r_q[s] <= r_out;
      d_q[s] <= d_in;
    end
  end

  assign quo = w_q[DIV_STAGES-1][U_W-1:0];

endmodule

// ----- hdl/loop_subdiv_vertex_point.sv -----
// ----------------------------------------------------------------------------
// loop_subdiv_vertex_point
// Loop subdivision vertex rule: repositions one old vertex per request run.
//
// A run is a center request (start_vertex high, with its boundary flag)
// followed by its one-ring neighbor requests; the request with last_item
// high closes the run. A request is taken on every clock edge where start
// is high; busy never rises, so one request per cycle is sustained.
// Interior vertices use the Warren weights, boundary vertices the 3/4, 1/8
// crease rule; results are rounded to nearest, ties up, and saturated.
// Each closed run gives one result on the result port, marked by done for
// exactly one cycle. The divider by the valence is pipelined and takes
// DIV_DIGIT quotient bits per stage. The receiver cannot stall the block,
// so results are never held back. Neighbor requests outside a run are
// dropped, and neighbors beyond MAX_VALENCE are dropped with status 2.
// Synchronous reset closes any open run and empties the pipeline.
// ----------------------------------------------------------------------------
module loop_subdiv_vertex_point import lsvp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  req_t    req,
  output logic    done,
  output result_t result
);

  logic  take;
  fin_t  fin;
  logic  fin_valid;
  prep_t prep;
  logic  prep_valid;
  mag_t  quo [3];
  side_t side_q [DIV_STAGES];
  logic  sv_q   [DIV_STAGES];
  pos_t  res_next [3];

  assign busy = 1'b0;
  assign take = start & ~busy;

  lsvp_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .req       (req),
    .fin       (fin),
    .fin_valid (fin_valid)
  );

  lsvp_prep u_prep (
    .clk        (clk),
    .rst        (rst),
    .fin        (fin),
    .fin_valid  (fin_valid),
    .prep       (prep),
    .prep_valid (prep_valid)
  );

  for (genvar k = 0; k < 3; k++) begin : g_lane
    lsvp_div u_div (
      .clk (clk),
      .num (prep.mag[k]),
      .den (prep.den),
      .quo (quo[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        sv_q[s] <= 1'b0;
      end
      done <= 1'b0;
    end else begin
      sv_q[0] <= prep_valid;
      for (int s = 1; s < DIV_STAGES; s++) begin
        sv_q[s] <= sv_q[s-1];
      end
      done <= sv_q[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    side_q[0].neg    <= prep.neg;
    side_q[0].status <= prep.status;
    for (int s = 1; s < DIV_STAGES; s++) begin
      side_q[s] <= side_q[s-1];
    end
  end

  always_comb begin
    logic signed [U_W:0] qs;
    logic                fits;
    for (int k = 0; k < 3; k++) begin
      qs = side_q[DIV_STAGES-1].neg[k] ? -$signed({1'b0, quo[k]}) : $signed({1'b0, quo[k]});
      fits = (&qs[U_W:POS_W-1]) | ~(|qs[U_W:POS_W-1]);
      if (fits) begin
        res_next[k] = qs[POS_W-1:0];
      end else if (qs[U_W]) begin
        res_next[k] = {1'b1, {(POS_W-1){1'b0}}};
      end else begin
        res_next[k] = {1'b0, {(POS_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    result.new_x  <= res_next[0];
    result.new_y  <= res_next[1];
    result.new_z  <= res_next[2];
    result.status <= side_q[DIV_STAGES-1].status;
  end

  a_done_tracks_prep : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(prep_valid, DIV_STAGES + 1))
    else $error("result strobe without a prepared run");

  a_fin_reaches_prep : assert property (@(posedge clk) disable iff (rst)
    fin_valid |-> ##3 prep_valid)
    else $error("closed run lost before the divider");

  a_den_nonzero : assert property (@(posedge clk) disable iff (rst)
    prep_valid |-> prep.den != '0)
    else $error("zero divisor handed to the divider");

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Testbench of the Loop subdivision vertex-point unit.
//
// Drives vertex runs (a center request, its one-ring neighbor requests, the
// closing request) through the command port and tracks the open run itself.
// For each closed run it works out the repositioned vertex and status, and
// each result that comes back is compared, field by field, with the oldest
// pending vertex. A short directed pass covers lone centers, stray neighbors,
// abandoned runs, rounding ties and extreme coordinates. Random runs follow,
// mostly well formed, some with too many neighbors or cut short, under
// several sender idle rates.
// ----------------------------------------------------------------------------
module tb import lsvp_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 40;

  class vertex_rule_tracker;
    longint  ctr[3];
    longint  nsum[3];
    longint  first_nbr[3];
    longint  last_nbr[3];
    bit      bnd_mode;
    int      nbr_count;
    bit      too_many;
    bit      run_open;
    result_t due_points[$];
    int      errors;

    function new();
      for (int k = 0; k < 3; k++) begin
        ctr[k] = 0;
        nsum[k] = 0;
        first_nbr[k] = 0;
        last_nbr[k] = 0;
      end
      bnd_mode = 0;
      nbr_count = 0;
      too_many = 0;
      run_open = 0;
      errors = 0;
    endfunction

    function longint floor_quot(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q--;
      return q;
    endfunction

    function longint round_quot(longint num, longint den);
      return floor_quot(2 * num + den, 2 * den);
    endfunction

    function pos_t clamp(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return pos_t'(v);
    endfunction

    function result_t reposition();
      result_t pt;
      longint  v[3];
      longint  n;
      n = nbr_count;
      pt.status = too_many ? ST_OVERFLOW : ST_OK;
      for (int k = 0; k < 3; k++) begin
        if (n == 0) begin
          v[k] = ctr[k];
          pt.status = ST_NO_NBR;
        end else if (bnd_mode) begin
          v[k] = round_quot(6 * ctr[k] + first_nbr[k] + last_nbr[k], 8);
        end else if (n == 3) begin
          v[k] = round_quot(7 * ctr[k] + 3 * nsum[k], 16);
        end else begin
          v[k] = round_quot(5 * n * ctr[k] + 3 * nsum[k], 8 * n);
        end
      end
      pt.new_x = clamp(v[0]);
      pt.new_y = clamp(v[1]);
      pt.new_z = clamp(v[2]);
      return pt;
    endfunction

    function void take_request(req_t r);
      longint p[3];
      p[0] = r.pos_x;
      p[1] = r.pos_y;
      p[2] = r.pos_z;
      if (r.start_vertex) begin
        for (int k = 0; k < 3; k++) begin
          ctr[k] = p[k];
          nsum[k] = 0;
          first_nbr[k] = 0;
          last_nbr[k] = 0;
        end
        bnd_mode = r.boundary;
        nbr_count = 0;
        too_many = 0;
        run_open = 1;
      end else begin
        if (!run_open) return;
        if (nbr_count < MAX_VALENCE) begin
          for (int k = 0; k < 3; k++) begin
            if (nbr_count == 0) first_nbr[k] = p[k];
            last_nbr[k] = p[k];
            nsum[k] += p[k];
          end
          nbr_count++;
        end else begin
          too_many = 1;
        end
      end
      if (r.last_item) begin
        due_points.push_back(reposition());
        run_open = 0;
      end
    endfunction

    task report(string msg);
      errors++;
      $display("%0t ns: %s", $time, msg);
    endtask

    task match_point(result_t got);
      result_t want;
      if (due_points.size() == 0) begin
        report($sformatf("result %h with no vertex pending", got));
      end else begin
        want = due_points.pop_front();
        if (got.new_x !== want.new_x)
          report($sformatf("new_x got %h want %h", got.new_x, want.new_x));
        if (got.new_y !== want.new_y)
          report($sformatf("new_y got %h want %h", got.new_y, want.new_y));
        if (got.new_z !== want.new_z)
          report($sformatf("new_z got %h want %h", got.new_z, want.new_z));
        if (got.status !== want.status)
          report($sformatf("status got %0d want %0d", got.status, want.status));
      end
    endtask
  endclass

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  req_t    req;
  logic    done;
  result_t result;

  vertex_rule_tracker board;
  int cycles;
  int accepted;
  int gap_pct;

  loop_subdiv_vertex_point dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .req    (req),
    .done   (done),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) board.match_point(result);
  end

  task drive(req_t r);
    while ($urandom_range(1, 100) <= gap_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.take_request(r);
    accepted++;
  endtask

  task send(logic sv, logic bd, logic lst, pos_t x, pos_t y, pos_t z);
    req_t r;
    r.start_vertex = sv;
    r.boundary = bd;
    r.last_item = lst;
    r.pos_x = x;
    r.pos_y = y;
    r.pos_z = z;
    drive(r);
  endtask

  function pos_t rand_pos();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3, 4: return pos_t'($signed($urandom_range(0, 2000)) - 1000);
      default: return pos_t'($urandom);
    endcase
  endfunction

  task random_point(logic sv, logic lst);
    send(sv, logic'($urandom_range(0, 1)), lst, rand_pos(), rand_pos(), rand_pos());
  endtask

  task random_run(int base_pct);
    int kind;
    int nbrs;
    kind = $urandom_range(0, 99);
    gap_pct = ($urandom_range(0, 4) == 0) ? 0 : base_pct;
    if (kind < 5) begin
      random_point(1'b0, logic'($urandom_range(0, 1)));
    end else if (kind < 10) begin
      nbrs = $urandom_range(0, 4);
      random_point(1'b1, 1'b0);
      for (int i = 0; i < nbrs; i++) random_point(1'b0, 1'b0);
    end else begin
      if (kind < 15) nbrs = 0;
      else if (kind < 25) nbrs = $urandom_range(MAX_VALENCE + 1, MAX_VALENCE + 4);
      else if (kind < 45) nbrs = 3;
      else nbrs = $urandom_range(1, MAX_VALENCE);
      random_point(1'b1, nbrs == 0);
      for (int i = 1; i <= nbrs; i++) random_point(1'b0, i == nbrs);
    end
  endtask

  task drain();
    @(negedge clk);
    start <= 1'b0;
    while (board.due_points.size() != 0) @(posedge clk);
  endtask

  initial begin
    int phase_pct[4];
    phase_pct = '{0, 81, 22, 0};
    board = new();
    accepted = 0;
    gap_pct = 0;
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    send(1'b0, 1'b1, 1'b1, 32'sh7fffffff, 32'sh80000000, 32'sh1);
    send(1'b1, 1'b1, 1'b1, 32'sh7fffffff, 32'sh80000000, 32'sh0);
    send(1'b1, 1'b0, 1'b0, 32'sh7fffffff, 32'sh80000000, 32'sh1);
    send(1'b0, 1'b1, 1'b0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    send(1'b0, 1'b0, 1'b0, 32'sh7fffffff, 32'sh80000000, 32'sh80000000);
    send(1'b0, 1'b1, 1'b1, 32'sh7fffffff, 32'sh80000000, 32'shffffffff);
    send(1'b1, 1'b1, 1'b0, 32'sh0, 32'sh0, 32'sh80000000);
    send(1'b0, 1'b0, 1'b0, 32'sh2, -32'sh2, 32'sh80000000);
    send(1'b0, 1'b0, 1'b1, 32'sh2, -32'sh2, 32'sh80000000);
    send(1'b1, 1'b0, 1'b0, 32'sh5, 32'sh5, 32'sh5);
    send(1'b0, 1'b0, 1'b0, 32'sh9, 32'sh9, 32'sh9);
    send(1'b1, 1'b0, 1'b0, 32'sh0, 32'sh0, 32'sh0);
    send(1'b0, 1'b1, 1'b1, 32'sh4, -32'sh4, 32'sh7fffffff);
    send(1'b0, 1'b0, 1'b1, 32'sh1234, 32'sh5678, 32'sh9abc);
    send(1'b1, 1'b0, 1'b0, 32'sh80000000, 32'sh7fffffff, -32'sh1);
    for (int i = 1; i <= 4; i++)
      send(1'b0, 1'b0, i == 4, 32'sh80000000, 32'sh7fffffff, 32'sh10000 * i);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      while (accepted < 100 * (ph + 1)) random_run(phase_pct[ph]);
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/lsvp_pkg.sv
hdl/lsvp_accum.sv
hdl/lsvp_prep.sv
hdl/lsvp_div.sv
hdl/loop_subdiv_vertex_point.sv
dv/tb.sv
